@@ design/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants for the drive state and torque supervisor.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int DEF_PEDAL_FRAC_BITS = 12;
  localparam int QDEPTH              = 2;
  localparam int QPTR_W              = $clog2(QDEPTH);
  localparam int QCNT_W              = $clog2(QDEPTH + 1);

  localparam logic [16:0] Q_ONE = 17'h10000;

  // configuration register indexes
  localparam logic [2:0] CFG_GAIN   = 3'd0;
  localparam logic [2:0] CFG_OFFSET = 3'd1;
  localparam logic [2:0] CFG_STEEP  = 3'd2;
  localparam logic [2:0] CFG_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_REV    = 3'd4;

  // drive phase codes
  localparam logic [2:0] PH_GLV       = 3'd0;
  localparam logic [2:0] PH_TSPRE     = 3'd1;
  localparam logic [2:0] PH_PRECHARGE = 3'd2;
  localparam logic [2:0] PH_COMPLETE  = 3'd3;
  localparam logic [2:0] PH_NULL      = 3'd4;
  localparam logic [2:0] PH_TORQUE    = 3'd5;
  localparam logic [2:0] PH_REGEN     = 3'd6;

  typedef struct packed {
    logic [16:0] gain;
    logic [16:0] offset;
    logic [10:0] steep;
    logic [11:0] limit;
    logic [15:0] rev;
  } cfg_t;

  // pedal and brake classification of one sample
  typedef struct packed {
    logic apps_go;     // mean pedal above 5 percent
    logic apps_low;    // mean pedal below 5 percent
    logic brake_hi;    // brake above 10 percent
    logic brake_lo;    // brake below 10 percent
    logic a1_quarter;  // sensor one above 25 percent
    logic diff_fault;  // sensor disagreement
    logic tp_hi;       // throttle above 5 percent
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [16:0] x;
    logic [15:0] rpm;
  } q_item_t;

  typedef struct packed {
    logic        fault;
    logic        viol;
    logic [2:0]  phase;
    logic [11:0] cur;
    logic        en;
  } res_t;

endpackage

@@ design/dts_front.sv @@
// ----------------------------------------------------------------------------
// dts_front
// Accept side: classifies each pedal sample and scales the throttle.
// ----------------------------------------------------------------------------
module dts_front
  import dts_pkg::*;
#(
  parameter int PEDAL_FRAC_BITS = DEF_PEDAL_FRAC_BITS
) (
  input  logic [12:0] apps_one,
  input  logic [12:0] apps_two,
  input  logic [12:0] throttle_position,
  input  logic [12:0] brake_front,
  input  logic [12:0] brake_rear,
  input  logic [15:0] motor_rpm,
  output q_item_t     item
);

  localparam logic [19:0] UNIT = 20'(1 << PEDAL_FRAC_BITS);
  localparam int          SH   = 16 - PEDAL_FRAC_BITS;

  logic [13:0] apps_sum;
  logic [13:0] brake_sum;
  logic [13:0] twice;
  logic [13:0] diff;
  logic [19:0] apps_x10;
  logic [19:0] brake_x10;
  logic [19:0] diff_x10;
  logic [19:0] tp_x20;
  logic [19:0] a1_x4;
  logic [20:0] x_wide;

  always_comb begin
    apps_sum  = {1'b0, apps_one} + {1'b0, apps_two};
    brake_sum = {1'b0, brake_front} + {1'b0, brake_rear};
    twice     = {apps_two, 1'b0};
    diff      = ({1'b0, apps_one} > twice) ? ({1'b0, apps_one} - twice)
                                           : (twice - {1'b0, apps_one});
    apps_x10  = 20'(apps_sum) * 20'd10;
    brake_x10 = 20'(brake_sum) * 20'd10;
    diff_x10  = 20'(diff) * 20'd10;
    tp_x20    = 20'(throttle_position) * 20'd20;
    a1_x4     = {5'b0, apps_one, 2'b0};
    x_wide    = 21'(throttle_position) << SH;

    item.cls.apps_go    = apps_x10 > UNIT;
    item.cls.apps_low   = apps_x10 < UNIT;
    item.cls.brake_hi   = brake_x10 > UNIT;
    item.cls.brake_lo   = brake_x10 < UNIT;
    item.cls.a1_quarter = a1_x4 > UNIT;
    item.cls.diff_fault = diff_x10 > UNIT;
    item.cls.tp_hi      = tp_x20 > UNIT;
    item.x   = (x_wide > 21'(Q_ONE)) ? Q_ONE : x_wide[16:0];
    item.rpm = motor_rpm;
  end

endmodule

@@ design/dts_queue.sv @@
// ----------------------------------------------------------------------------
// dts_queue
// Short queue between the classify side and the drive state engine.
// ----------------------------------------------------------------------------
module dts_queue
  import dts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output q_item_t head
);

  q_item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

@@ design/dts_back.sv @@
// ----------------------------------------------------------------------------
// dts_back
// Drive state engine with a shared multiplier, a bit-serial divider and a
// bit-serial square root for the torque curve.
// ----------------------------------------------------------------------------
module dts_back
  import dts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    head_valid,
  input  q_item_t head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DIV     = 4'd1;
  localparam logic [3:0] ST_INT     = 4'd2;
  localparam logic [3:0] ST_SQRT    = 4'd3;
  localparam logic [3:0] ST_ROOTMUL = 4'd4;
  localparam logic [3:0] ST_T1      = 4'd5;
  localparam logic [3:0] ST_T2      = 4'd6;
  localparam logic [3:0] ST_T3      = 4'd7;
  localparam logic [3:0] ST_ZC      = 4'd8;
  localparam logic [3:0] ST_CUR     = 4'd9;
  localparam logic [3:0] ST_DONE    = 4'd10;

  logic [3:0]  st_r;
  logic [2:0]  phase_r;
  logic        viol_r;
  logic        en_r;
  logic [11:0] cur_r;
  logic        out_valid_r;
  res_t        out_r;

  logic [16:0] x_r;
  logic [16:0] y_r;
  logic [16:0] rem_r;
  logic [4:0]  cnt_r;
  logic [2:0]  int_cnt_r;
  logic [2:0]  root_i_r;
  logic [16:0] r_r;
  logic [16:0] s_r;
  logic [33:0] sq_v_r;
  logic [33:0] sq_res_r;
  logic [17:0] t_r;
  logic [16:0] z_r;

  logic        out_free;
  logic        out_load;
  logic [2:0]  nx_phase;
  logic        nx_viol;
  logic        nx_en;
  logic [11:0] nx_cur;
  logic        nx_fault;
  logic        go_torque;
  logic [16:0] b_sat;
  logic [16:0] k_sat;
  logic [17:0] mul_a;
  logic [17:0] mul_b;
  logic [35:0] prod;
  logic [17:0] qm;
  logic [17:0] rem2;
  logic        div_ge;
  logic [33:0] bitv;
  logic [33:0] sq_sum;
  logic        sq_ge;
  logic [33:0] sq_v_n;
  logic [33:0] sq_res_n;

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = (st_r == ST_IDLE) && head_valid && out_free;
  assign out_load  = (pop && !go_torque) || ((st_r == ST_DONE) && out_free);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  assign b_sat = (cfg.offset > Q_ONE) ? Q_ONE : cfg.offset;
  assign k_sat = (cfg.gain > Q_ONE) ? Q_ONE : cfg.gain;

  // drive state decision for the item at the head of the queue
  always_comb begin
    nx_phase  = phase_r;
    nx_viol   = viol_r;
    nx_en     = en_r;
    nx_cur    = cur_r;
    nx_fault  = 1'b0;
    go_torque = 1'b0;
    unique case (phase_r)
      PH_TSPRE, PH_PRECHARGE, PH_COMPLETE: begin
        nx_phase = phase_r + 3'd1;
        nx_en    = 1'b0;
        nx_cur   = '0;
      end
      PH_NULL: begin
        nx_en  = 1'b0;
        nx_cur = '0;
        if (!viol_r && head.cls.apps_go) begin
          nx_phase = PH_TORQUE;
        end else if (!viol_r && head.cls.brake_hi) begin
          nx_phase = PH_REGEN;
        end else if (viol_r && head.cls.apps_low) begin
          nx_viol = 1'b0;
        end
      end
      PH_TORQUE: begin
        if (head.cls.diff_fault) begin
          nx_fault = 1'b1;
          nx_phase = PH_NULL;
        end else if (head.cls.brake_hi && head.cls.a1_quarter) begin
          nx_viol  = 1'b1;
          nx_phase = PH_NULL;
        end else begin
          nx_en     = 1'b1;
          go_torque = 1'b1;
        end
      end
      PH_REGEN: begin
        if (head.cls.tp_hi) begin
          nx_phase = PH_TORQUE;
        end else if (head.cls.brake_lo) begin
          nx_phase = PH_NULL;
        end else begin
          nx_en  = 1'b1;
          nx_cur = '0;
        end
      end
      default: begin
        nx_phase = PH_TSPRE;
        nx_en    = 1'b0;
        nx_cur   = '0;
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      ST_INT: begin
        mul_a = {1'b0, r_r};
        mul_b = {1'b0, y_r};
      end
      ST_ROOTMUL: begin
        mul_a = {1'b0, r_r};
        mul_b = {1'b0, s_r};
      end
      ST_T1: begin
        mul_a = {1'b0, Q_ONE - x_r};
        mul_b = {1'b0, x_r} + {1'b0, b_sat};
      end
      ST_T2: begin
        mul_a = t_r;
        mul_b = {1'b0, r_r};
      end
      ST_T3: begin
        mul_a = t_r;
        mul_b = {1'b0, k_sat};
      end
      ST_CUR: begin
        mul_a = {1'b0, z_r};
        mul_b = {6'b0, cfg.limit};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
    qm   = prod[33:16];
  end

  // one divider step and one square root step
  always_comb begin
    rem2     = {rem_r, 1'b0};
    div_ge   = rem2 >= {2'b0, cfg.rev};
    bitv     = 34'd1 << {cnt_r, 1'b0};
    sq_sum   = sq_res_r + bitv;
    sq_ge    = sq_v_r >= sq_sum;
    sq_v_n   = sq_ge ? (sq_v_r - sq_sum) : sq_v_r;
    sq_res_n = sq_ge ? ((sq_res_r >> 1) + bitv) : (sq_res_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      phase_r     <= PH_GLV;
      viol_r      <= 1'b0;
      en_r        <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (pop) begin
            phase_r <= nx_phase;
            viol_r  <= nx_viol;
            en_r    <= nx_en;
            if (go_torque) begin
              x_r       <= head.x;
              r_r       <= Q_ONE;
              int_cnt_r <= cfg.steep[10:8];
              if ({1'b0, head.rpm} >= {1'b0, cfg.rev}) begin
                y_r  <= Q_ONE;
                st_r <= ST_INT;
              end else begin
                y_r   <= '0;
                rem_r <= {1'b0, head.rpm};
                cnt_r <= 5'd16;
                st_r  <= ST_DIV;
              end
            end else begin
              cur_r <= nx_cur;
              out_r <= '{fault: nx_fault, viol: nx_viol, phase: nx_phase,
                         cur: nx_cur, en: nx_en};
            end
          end
        end
        ST_DIV: begin
          rem_r <= div_ge ? 17'(rem2 - {2'b0, cfg.rev}) : rem2[16:0];
          y_r   <= {y_r[15:0], div_ge};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            st_r <= ST_INT;
          end
        end
        ST_INT: begin
          if (int_cnt_r == 3'd0) begin
            s_r      <= y_r;
            sq_v_r   <= {1'b0, y_r, 16'b0};
            sq_res_r <= '0;
            cnt_r    <= 5'd16;
            root_i_r <= 3'd0;
            st_r     <= ST_SQRT;
          end else begin
            r_r       <= qm[16:0];
            int_cnt_r <= int_cnt_r - 3'd1;
          end
        end
        ST_SQRT: begin
          sq_v_r   <= sq_v_n;
          sq_res_r <= sq_res_n;
          if (cnt_r == 5'd0) begin
            s_r  <= sq_res_n[16:0];
            st_r <= ST_ROOTMUL;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        ST_ROOTMUL: begin
          if (cfg.steep[~root_i_r]) begin
            r_r <= qm[16:0];
          end
          if (root_i_r == 3'd7) begin
            st_r <= ST_T1;
          end else begin
            root_i_r <= root_i_r + 3'd1;
            sq_v_r   <= {1'b0, s_r, 16'b0};
            sq_res_r <= '0;
            cnt_r    <= 5'd16;
            st_r     <= ST_SQRT;
          end
        end
        ST_T1: begin
          t_r  <= qm;
          st_r <= ST_T2;
        end
        ST_T2: begin
          t_r  <= qm;
          st_r <= ST_T3;
        end
        ST_T3: begin
          t_r  <= qm;
          st_r <= ST_ZC;
        end
        ST_ZC: begin
          z_r  <= (t_r >= {1'b0, x_r}) ? '0 : 17'({1'b0, x_r} - t_r);
          st_r <= ST_CUR;
        end
        ST_CUR: begin
          cur_r <= prod[27:16];
          st_r  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_r <= '{fault: 1'b0, viol: viol_r, phase: phase_r,
                       cur: cur_r, en: en_r};
            st_r  <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/drive_state_torque_supervisor_top.sv @@
// ----------------------------------------------------------------------------
// drive_state_torque_supervisor_top
// Drive state sequencing and torque request for one pedal and motor sample.
// ----------------------------------------------------------------------------
// Each input word is one pedal and motor sample and yields exactly one result
// word: drive enable, current request, next drive state, latched violation
// and pedal fault. After reset the block walks glv, tsprecharge, precharging
// and complete with drive off, then runs null, torque and regen. A torque
// step computes clip(x-(1-x)(x+b)(y^p)k,0,1) times current_limit in Q0.16.
// A step that does not compute torque leaves the state engine idle, so the
// block sustains one word per cycle while the result side is ready; a word
// is registered in the queue and then in the output register. A torque step
// holds the state engine while the back end runs a 16-step serial divide for
// the load (skipped when the speed is at or above the rev limit), up to seven
// integer-power multiplies, eight 17-step square roots for the fractional
// exponent and five curve steps on one shared multiplier.
// A two-word queue sits between the classify side and the state engine, and
// the result waits in an output register, so input is taken while a result
// is still pending. The user must write configuration only while idle; the
// block itself does not enforce it.
module drive_state_torque_supervisor_top
  import dts_pkg::*;
#(
  parameter int PEDAL_FRAC_BITS = DEF_PEDAL_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // apps_one[12:0], apps_two[25:13], throttle_position[38:26],
  // brake_front[51:39], brake_rear[64:52], motor_rpm[80:65], zero pad
  input  logic [87:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // drive_enable[0], current_request[12:1], next_state[15:13],
  // violation_flag[16], apps_fault[17], zero pad
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata
);

  cfg_t    cfg_r;
  q_item_t front_item;
  q_item_t head;
  logic    q_full;
  logic    head_valid;
  logic    pop;
  logic    push;
  res_t    res;

  // hold configuration registers; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{gain: 17'd0, offset: 17'd0, steep: 11'd256, limit: 12'd0,
                 rev: 16'd5500};
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GAIN:   cfg_r.gain   <= cfg_wdata;
        CFG_OFFSET: cfg_r.offset <= cfg_wdata;
        CFG_STEEP:  cfg_r.steep  <= cfg_wdata[10:0];
        CFG_LIMIT:  cfg_r.limit  <= cfg_wdata[11:0];
        CFG_REV:    cfg_r.rev    <= cfg_wdata[15:0];
        default:    ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  // classify the sample as it arrives
  dts_front #(
    .PEDAL_FRAC_BITS(PEDAL_FRAC_BITS)
  ) u_front (
    .apps_one         (in_tdata[12:0]),
    .apps_two         (in_tdata[25:13]),
    .throttle_position(in_tdata[38:26]),
    .brake_front      (in_tdata[51:39]),
    .brake_rear       (in_tdata[64:52]),
    .motor_rpm        (in_tdata[80:65]),
    .item             (front_item)
  );

  dts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_item),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  // advance drive state and compute the torque request
  dts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {6'b0, res.fault, res.viol, res.phase, res.cur, res.en};

endmodule

@@ design/dts_checker.sv @@
// ----------------------------------------------------------------------------
// dts_checker
// Port-level checks on the supervisor's result stream.
// ----------------------------------------------------------------------------
module dts_checker
  import dts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_startup_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15:13] == PH_TSPRE || out_tdata[15:13] == PH_PRECHARGE ||
                   out_tdata[15:13] == PH_COMPLETE)
    |-> out_tdata[0] == 1'b0 && out_tdata[12:1] == 12'd0)
    else $error("drive enabled during start-up");

  a_fault_to_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[15:13] == PH_NULL)
    else $error("pedal fault did not fall back to null");

  a_no_glv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:13] != PH_GLV && out_tdata[15:13] <= PH_REGEN)
    else $error("invalid next state reported");

endmodule

bind drive_state_torque_supervisor_top dts_checker u_dts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

@@ dv/dts_supervisor_checker.sv @@
// ----------------------------------------------------------------------------
// dts_supervisor_checker
// Predicts the supervisor's command for every accepted sample word and checks
// each result word against it, field by field, in order.
// ----------------------------------------------------------------------------
module dts_supervisor_checker
  import dts_pkg::*;
#(
  parameter int PEDAL_FRAC_BITS = DEF_PEDAL_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [87:0] in_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata,
  output int          mismatches,
  output int          cmds_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        fault;
    logic        viol;
    logic [2:0]  phase;
    logic [11:0] cur;
    logic        en;
  } cmd_t;

  localparam longint unsigned ONE = 64'h10000;

  cmd_t        pending_cmds[$];
  logic [16:0] k_gain, b_offset;
  logic [10:0] p_steep;
  logic [11:0] i_limit;
  logic [15:0] rpm_limit;
  logic [2:0]  phase;
  logic        viol_latched, en_held;
  logic [11:0] cur_held;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // y^p in Q0.16: integer power, then the chain of square roots
  function automatic longint unsigned load_pow(input longint unsigned y,
                                                input logic [10:0] p);
    longint unsigned r, s;
    r = ONE;
    s = y;
    for (int i = 0; i < p[10:8]; i++) r = (r * y) >> 16;
    for (int i = 0; i < 8; i++) begin
      s = int_sqrt(s << 16);
      if (p[7-i]) r = (r * s) >> 16;
    end
    return r;
  endfunction

  function automatic logic [11:0] torque_amps(input logic [12:0] tp,
                                              input logic [15:0] rpm);
    longint unsigned x, y, b, k, term, z;
    x = longint'(tp) << (16 - PEDAL_FRAC_BITS);
    if (x > ONE) x = ONE;
    b = (b_offset > ONE) ? ONE : b_offset;
    k = (k_gain > ONE) ? ONE : k_gain;
    if (rpm_limit == 0) y = ONE;
    else y = (longint'(rpm) << 16) / rpm_limit;
    if (y > ONE) y = ONE;
    term = ((((((ONE - x) * (x + b)) >> 16) * load_pow(y, p_steep)) >> 16) * k) >> 16;
    z = (term >= x) ? 0 : x - term;
    return 12'((z * i_limit) >> 16);
  endfunction

  task automatic supervise_step(input logic [87:0] w);
    longint unsigned a1, a2, tp, brk, aps, unit, twice, diff;
    logic [2:0] nxt;
    cmd_t c;
    a1 = w[12:0];
    a2 = w[25:13];
    tp = w[38:26];
    brk = longint'(w[51:39]) + w[64:52];
    aps = a1 + a2;
    unit = 64'd1 << PEDAL_FRAC_BITS;
    c.fault = 1'b0;
    case (phase)
      PH_TSPRE: begin nxt = PH_PRECHARGE; en_held = 0; cur_held = 0; end
      PH_PRECHARGE: begin nxt = PH_COMPLETE; en_held = 0; cur_held = 0; end
      PH_COMPLETE: begin nxt = PH_NULL; en_held = 0; cur_held = 0; end
      PH_NULL: begin
        en_held = 0;
        cur_held = 0;
        nxt = PH_NULL;
        if (!viol_latched && 10 * aps > unit) nxt = PH_TORQUE;
        else if (!viol_latched && 10 * brk > unit) nxt = PH_REGEN;
        else if (viol_latched && 10 * aps < unit) viol_latched = 0;
      end
      PH_TORQUE: begin
        twice = 2 * a2;
        diff = (a1 > twice) ? a1 - twice : twice - a1;
        if (10 * diff > unit) begin
          c.fault = 1'b1;
          nxt = PH_NULL;
        end else if (10 * brk > unit && 4 * a1 > unit) begin
          viol_latched = 1;
          nxt = PH_NULL;
        end else begin
          en_held = 1;
          cur_held = torque_amps(w[38:26], w[80:65]);
          nxt = PH_TORQUE;
        end
      end
      PH_REGEN: begin
        if (20 * tp > unit) nxt = PH_TORQUE;
        else if (10 * brk < unit) nxt = PH_NULL;
        else begin
          en_held = 1;
          cur_held = 0;
          nxt = PH_REGEN;
        end
      end
      default: begin nxt = PH_TSPRE; en_held = 0; cur_held = 0; end
    endcase
    phase = nxt;
    c.en = en_held;
    c.cur = cur_held;
    c.phase = phase;
    c.viol = viol_latched;
    pending_cmds.push_back(c);
  endtask

  task automatic report(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d actual %0d at %0t", what, exp_v, act_v, $realtime);
  endtask

  always @(posedge clk) begin
    cmd_t got, want;
    if (!rst_n) begin
      pending_cmds.delete();
      k_gain <= 0; b_offset <= 0; p_steep <= 11'd256; i_limit <= 0; rpm_limit <= 16'd5500;
      phase = PH_GLV; viol_latched = 0; en_held = 0; cur_held = 0;
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GAIN:   k_gain <= cfg_wdata;
          CFG_OFFSET: b_offset <= cfg_wdata;
          CFG_STEEP:  p_steep <= cfg_wdata[10:0];
          CFG_LIMIT:  i_limit <= cfg_wdata[11:0];
          CFG_REV:    rpm_limit <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) supervise_step(in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata[17:0];
        if (pending_cmds.size() == 0) begin
          report("unexpected word", 0, int'(got));
        end else begin
          want = pending_cmds.pop_front();
          if (got.en !== want.en) report("drive_enable", want.en, got.en);
          if (got.cur !== want.cur) report("current_request", want.cur, got.cur);
          if (got.phase !== want.phase) report("next_state", want.phase, got.phase);
          if (got.viol !== want.viol) report("violation_flag", want.viol, got.viol);
          if (got.fault !== want.fault) report("apps_fault", want.fault, got.fault);
        end
      end
    end
    cmds_pending = pending_cmds.size();
  end

endmodule

@@ dv/drive_state_torque_supervisor_top_tb.sv @@
// ----------------------------------------------------------------------------
// drive_state_torque_supervisor_top_tb
// Drives directed and random pedal/motor samples through the supervisor over
// several curve settings, with bursty input and a stalling result side; the
// checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module drive_state_torque_supervisor_top_tb
  import dts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3_000_000;  // cycles

  logic        clk = 0;
  logic        rst_n = 0;
  logic [87:0] in_tdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = CFG_GAIN;
  logic [16:0] cfg_wdata = '0;
  int          mismatches, cmds_pending;
  int          cycles = 0;
  int          burst_left = 0;
  int          ready_mode = 0, mode_left = 0;

  drive_state_torque_supervisor_top dut (.*);

  dts_supervisor_checker chk (.*);

  initial forever #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: switch among always-ready, coin-flip and mostly-stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // send one sample word; bursts of random length, mostly separated by random gaps
  task automatic send_sample(input int a1, a2, tp, bf, br, rpm);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1;
    in_tdata <= {7'd0, 16'(rpm), 13'(br), 13'(bf), 13'(tp), 13'(a2), 13'(a1)};
    // ready is registered state, so its mid-cycle value holds at the next edge
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // hold input until every result is back, then let the block settle
  task automatic drain();
    in_tvalid <= 0;
    do @(posedge clk); while (cmds_pending != 0);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= 17'(val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic load_curve(input int k, b, p, lim, rev);
    write_reg(CFG_GAIN, k);
    write_reg(CFG_OFFSET, b);
    write_reg(CFG_STEEP, p);
    write_reg(CFG_LIMIT, lim);
    write_reg(CFG_REV, rev);
    @(posedge clk);
  endtask

  // mostly consistent pedals and light brakes so torque steps dominate
  task automatic random_sample();
    int a1, a2, tp, bf, br, rpm;
    a1 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 4096);
    if ($urandom_range(0, 9) < 8) begin
      a2 = a1 / 2 + $urandom_range(0, 400) - 200;
      if (a2 < 0) a2 = 0;
      if (a2 > 4096) a2 = 4096;
    end else begin
      a2 = $urandom_range(0, 4096);
    end
    tp = ($urandom_range(0, 9) == 0) ? 4096 : $urandom_range(0, 4096);
    if ($urandom_range(0, 9) < 7) begin
      bf = $urandom_range(0, 220);
      br = $urandom_range(0, 220);
    end else begin
      bf = $urandom_range(0, 4096);
      br = $urandom_range(0, 4096);
    end
    case ($urandom_range(0, 5))
      0: rpm = 0;
      1: rpm = 65535;
      2: rpm = $urandom_range(0, 8000);
      default: rpm = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 49) == 0) begin
      a1 = 4096; a2 = 4096; tp = 4096; bf = 4096; br = 4096;
    end
    send_sample(a1, a2, tp, bf, br, rpm);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    load_curve(32768, 16384, 256, 4095, 5500);

    // start-up walk with all-zero and all-max words
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(4096, 4096, 4096, 4096, 4096, 65535);
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(4096, 4096, 4096, 4096, 4096, 65535);
    // null: pedal released stays, brake pressed goes to regen
    send_sample(100, 50, 0, 0, 0, 0);
    send_sample(0, 0, 0, 300, 200, 0);
    send_sample(0, 0, 0, 300, 300, 100);    // regen held
    send_sample(0, 0, 4096, 300, 300, 100); // throttle pulls regen to torque
    // torque extremes of throttle and speed
    send_sample(2000, 1000, 0, 0, 0, 0);
    send_sample(4096, 2048, 4096, 0, 0, 65535);
    send_sample(4096, 2048, 2048, 0, 0, 5500);
    send_sample(1000, 500, 1000, 0, 0, 2750);
    // sensor disagreement drops to null
    send_sample(4096, 0, 4096, 0, 0, 1000);
    send_sample(2000, 1000, 2000, 0, 0, 1000);
    // brake with pedal latches the violation
    send_sample(2000, 1000, 2000, 300, 300, 1000);
    send_sample(2000, 1000, 2000, 0, 0, 1000); // latched, pedal still down
    send_sample(50, 20, 0, 0, 0, 0);           // pedal released clears it
    send_sample(0, 0, 0, 400, 0, 0);           // brake below threshold, stays in null
    send_sample(0, 0, 0, 0, 100, 0);           // light brake, stays in null
    drain();

    // high settings of every register, then low corners and zero rev limit
    load_curve(65536, 65536, 1280, 4095, 65535);
    repeat (250) random_sample();
    drain();
    load_curve(0, 0, 0, 0, 1);
    repeat (150) random_sample();
    drain();
    load_curve(49152, 8192, 640, 2000, 0);
    repeat (150) random_sample();
    drain();
    load_curve(65536, 0, 1, 4095, 1);
    repeat (100) random_sample();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      load_curve($urandom_range(0, 65536), $urandom_range(0, 65536),
                 $urandom_range(0, 1280), $urandom_range(0, 4095),
                 $urandom_range(1, 65535));
      repeat (150) random_sample();
      drain();
    end

    if (mismatches == 0 && cmds_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
